### rtl/core/contingency_pair_counter_core_macros.svh
// Assertion helpers for the contingency pair counter core.
// They expect a clock named clk and an active-low reset named arst_n in scope.
`ifndef CONTINGENCY_PAIR_COUNTER_CORE_MACROS_SVH
`define CONTINGENCY_PAIR_COUNTER_CORE_MACROS_SVH

`ifndef SYNTHESIS
`define CPC_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error("contingency pair counter assertion failed");
`define CPC_NEVER(lbl, expr) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(expr)) \
		else $error("contingency pair counter forbidden condition seen");
`else
`define CPC_ASSERT(lbl, prop)
`define CPC_NEVER(lbl, expr)
`endif

`endif

### rtl/core/cpc_pkg.sv
package cpc_pkg;

	// Table geometry.
	localparam int MAX_COLUMNS = 64;
	localparam int COL_AW = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
	localparam int CFG_W = 7;
	localparam int CMP_W = (COL_AW + 1 > CFG_W) ? COL_AW + 1 : CFG_W;
	localparam logic [CFG_W-1:0] COLS_RESET = 7'd64;

	// Datapath widths.
	localparam int CNT_W = 16;
	localparam int COLT_W = 40;
	localparam int PRE_W = 48;
	localparam int ACC_W = 63;
	localparam int PROD_W = 64;
	localparam int HALF_W = 31;

	localparam logic [COLT_W-1:0] LIM40 = {COLT_W{1'b1}};
	localparam logic [PRE_W-1:0] LIM48 = {PRE_W{1'b1}};
	localparam logic [ACC_W-1:0] LIM63 = {ACC_W{1'b1}};

	// Result queue.
	localparam int OUT_DEPTH = 4;
	localparam int OUT_AW = 2;
	localparam int PEND_W = 3;

	typedef struct packed {
		logic [ACC_W-1:0] concordant;
		logic [ACC_W-1:0] discordant;
		logic [ACC_W-1:0] ties_rows;
		logic [ACC_W-1:0] ties_columns;
		logic [ACC_W-1:0] ties_joint;
	} result_t;

endpackage

### rtl/core/contingency_pair_counter_core.sv
// Contingency pair counter: cells of a contingency table arrive in row-major order, one
// cell_count per transaction, with last_cell set on the final cell. The core accepts one
// cell per clock cycle while cell_stall is low; the rate is set by the read-modify-write
// of the per-column totals memory, which is read when a cell is accepted and written back
// in the following cycle, with the just-written total forwarded to a following cell
// in the same column. A result transaction holds concordant, discordant and the three tie
// counts, each saturating at 2^63-1. Up to four finished tables may wait at the output;
// with four results outstanding the cell input stalls until the consumer takes one.
// Column totals are cleared at once after each table and after reset through per-column
// valid bits, so there is no clearing pass. The user must write columns_in_use through
// the configuration channel only while the core is idle; the core does not enforce it.
// Zero acts as one column and values above 64 act as 64.
`include "contingency_pair_counter_core_macros.svh"

module contingency_pair_counter_core (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_valid,
	output logic cfg_ready,
	input  logic [cpc_pkg::CFG_W-1:0] columns_in_use,
	input  logic cell_valid,
	output logic cell_stall,
	input  logic [cpc_pkg::CNT_W-1:0] cell_count,
	input  logic last_cell,
	output logic result_valid,
	input  logic result_stall,
	output logic [cpc_pkg::ACC_W-1:0] concordant,
	output logic [cpc_pkg::ACC_W-1:0] discordant,
	output logic [cpc_pkg::ACC_W-1:0] ties_rows,
	output logic [cpc_pkg::ACC_W-1:0] ties_columns,
	output logic [cpc_pkg::ACC_W-1:0] ties_joint
);

	// Saturate a grown sum at 2^63-1.
	function automatic logic [cpc_pkg::ACC_W-1:0] sat63(input logic [cpc_pkg::ACC_W+1:0] s);
		logic [cpc_pkg::ACC_W+1:0] lim;
		lim = {2'b00, cpc_pkg::LIM63};
		return (s > lim) ? cpc_pkg::LIM63 : s[cpc_pkg::ACC_W-1:0];
	endfunction

	// Configuration register. Writes are always taken.
	logic [cpc_pkg::CFG_W-1:0] cols_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cols_q <= cpc_pkg::COLS_RESET;
		end else if (cfg_valid && cfg_ready) begin
			cols_q <= columns_in_use;
		end
	end

	// Front end: column index, memory read and valid bit lookup at accept time.
	logic cell_acc;
	logic [cpc_pkg::CMP_W-1:0] cols_ext;
	logic [cpc_pkg::CMP_W-1:0] cols_eff;
	logic [cpc_pkg::CMP_W-1:0] j_inc;
	logic row_end0;
	logic [cpc_pkg::COL_AW-1:0] ci_q;
	logic [cpc_pkg::PEND_W-1:0] pend_q;

	assign cell_stall = (pend_q >= cpc_pkg::PEND_W'(cpc_pkg::OUT_DEPTH));
	assign cell_acc = cell_valid && !cell_stall;

	always_comb begin
		cols_ext = cpc_pkg::CMP_W'(cols_q);
		if (cols_ext == '0) begin
			cols_eff = cpc_pkg::CMP_W'(1);
		end else if (cols_ext > cpc_pkg::CMP_W'(cpc_pkg::MAX_COLUMNS)) begin
			cols_eff = cpc_pkg::CMP_W'(cpc_pkg::MAX_COLUMNS);
		end else begin
			cols_eff = cols_ext;
		end
		j_inc = cpc_pkg::CMP_W'(ci_q) + cpc_pkg::CMP_W'(1);
		row_end0 = (j_inc >= cols_eff);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ci_q <= '0;
		end else if (cell_acc) begin
			if (last_cell || row_end0) begin
				ci_q <= '0;
			end else begin
				ci_q <= j_inc[cpc_pkg::COL_AW-1:0];
			end
		end
	end

	// Stage 1 registers.
	logic v_s1;
	logic [cpc_pkg::CNT_W-1:0] c_s1;
	logic last_s1;
	logic rowend_s1;
	logic [cpc_pkg::COL_AW-1:0] addr_s1;
	logic vld_s1;
	logic hz_s1;
	logic [cpc_pkg::COLT_W-1:0] rd_s1;

	// Column totals memory and its valid bits.
	logic [cpc_pkg::COLT_W-1:0] colt_mem [cpc_pkg::MAX_COLUMNS];
	logic [cpc_pkg::MAX_COLUMNS-1:0] vbit_q;
	logic [cpc_pkg::COLT_W-1:0] colt_new;

	always_ff @(posedge clk) begin
		if (cell_acc) begin
			rd_s1 <= colt_mem[ci_q];
		end
		if (v_s1) begin
			colt_mem[addr_s1] <= colt_new;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vbit_q <= '0;
		end else if (v_s1) begin
			if (last_s1) begin
				vbit_q <= '0;
			end else begin
				vbit_q[addr_s1] <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= cell_acc;
		end
	end

	always_ff @(posedge clk) begin
		if (cell_acc) begin
			c_s1 <= cell_count;
			last_s1 <= last_cell;
			rowend_s1 <= row_end0;
			addr_s1 <= ci_q;
			vld_s1 <= vbit_q[ci_q];
			// A write-back at this same edge is not yet visible in the read data.
			hz_s1 <= v_s1;
		end
	end

	// Write-back forwarding register: the write that happened at the last edge.
	logic [cpc_pkg::COL_AW-1:0] fwd_addr_q;
	logic [cpc_pkg::COLT_W-1:0] fwd_data_q;
	logic fwd_last_q;

	always_ff @(posedge clk) begin
		if (v_s1) begin
			fwd_addr_q <= addr_s1;
			fwd_data_q <= colt_new;
			fwd_last_q <= last_s1;
		end
	end

	// Stage 1: recover the old column total and update the running sums.
	logic [cpc_pkg::PRE_W-1:0] lp_q;
	logic [cpc_pkg::PRE_W-1:0] ert_q;
	logic [cpc_pkg::COLT_W-1:0] crs_q;
	logic [cpc_pkg::COLT_W-1:0] old;
	logic [cpc_pkg::PRE_W-1:0] old48;
	logic [cpc_pkg::PRE_W-1:0] diff;
	logic [cpc_pkg::PRE_W-1:0] upright;
	logic [cpc_pkg::PRE_W:0] lp_sum;
	logic [cpc_pkg::PRE_W-1:0] lp_new;
	logic [cpc_pkg::COLT_W:0] colt_sum;
	logic [cpc_pkg::COLT_W:0] crs_sum;
	logic [cpc_pkg::COLT_W-1:0] crs_new;
	logic [cpc_pkg::PRE_W:0] ert_sum;
	logic [cpc_pkg::PRE_W-1:0] ert_new;

	always_comb begin
		if (hz_s1 && fwd_last_q) begin
			old = '0;
		end else if (hz_s1 && (fwd_addr_q == addr_s1)) begin
			old = fwd_data_q;
		end else if (vld_s1) begin
			old = rd_s1;
		end else begin
			old = '0;
		end
		old48 = cpc_pkg::PRE_W'(old);

		// Cells above and to the right; zero if saturation left the sums inconsistent.
		diff = ert_q - lp_q;
		if ((lp_q > ert_q) || (old48 > diff)) begin
			upright = '0;
		end else begin
			upright = diff - old48;
		end

		lp_sum = {1'b0, lp_q} + {1'b0, old48};
		lp_new = lp_sum[cpc_pkg::PRE_W] ? cpc_pkg::LIM48 : lp_sum[cpc_pkg::PRE_W-1:0];

		colt_sum = {1'b0, old} + (cpc_pkg::COLT_W+1)'(c_s1);
		colt_new = colt_sum[cpc_pkg::COLT_W] ? cpc_pkg::LIM40 : colt_sum[cpc_pkg::COLT_W-1:0];

		crs_sum = {1'b0, crs_q} + (cpc_pkg::COLT_W+1)'(c_s1);
		crs_new = crs_sum[cpc_pkg::COLT_W] ? cpc_pkg::LIM40 : crs_sum[cpc_pkg::COLT_W-1:0];

		ert_sum = {1'b0, ert_q} + (cpc_pkg::PRE_W+1)'(crs_new);
		ert_new = ert_sum[cpc_pkg::PRE_W] ? cpc_pkg::LIM48 : ert_sum[cpc_pkg::PRE_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lp_q <= '0;
			ert_q <= '0;
			crs_q <= '0;
		end else if (v_s1) begin
			if (last_s1) begin
				lp_q <= '0;
				ert_q <= '0;
				crs_q <= '0;
			end else if (rowend_s1) begin
				ert_q <= ert_new;
				crs_q <= '0;
				lp_q <= '0;
			end else begin
				lp_q <= lp_new;
				crs_q <= crs_new;
			end
		end
	end

	// Stage 2: multiplier operands.
	logic v_s2;
	logic last_s2;
	logic [cpc_pkg::CNT_W-1:0] c_s2;
	logic [cpc_pkg::PRE_W-1:0] lp_s2;
	logic [cpc_pkg::PRE_W-1:0] up_s2;
	logic [cpc_pkg::COLT_W-1:0] crs_s2;
	logic [cpc_pkg::COLT_W-1:0] old_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (v_s1) begin
			last_s2 <= last_s1;
			c_s2 <= c_s1;
			lp_s2 <= lp_q;
			up_s2 <= upright;
			crs_s2 <= crs_q;
			old_s2 <= old;
		end
	end

	logic [cpc_pkg::CNT_W-1:0] c_m1;
	logic [2*cpc_pkg::CNT_W-1:0] hprod;

	always_comb begin
		c_m1 = (c_s2 == '0) ? '0 : c_s2 - cpc_pkg::CNT_W'(1);
		hprod = (2*cpc_pkg::CNT_W)'(c_s2) * (2*cpc_pkg::CNT_W)'(c_m1);
	end

	// Stage 3: products, then accumulation.
	logic v_s3;
	logic last_s3;
	logic [cpc_pkg::PROD_W-1:0] p0_s3;
	logic [cpc_pkg::PROD_W-1:0] p1_s3;
	logic [cpc_pkg::PROD_W-1:0] p2_s3;
	logic [cpc_pkg::PROD_W-1:0] p3_s3;
	logic [cpc_pkg::HALF_W-1:0] half_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (v_s2) begin
			last_s3 <= last_s2;
			p0_s3 <= cpc_pkg::PROD_W'(c_s2) * cpc_pkg::PROD_W'(lp_s2);
			p1_s3 <= cpc_pkg::PROD_W'(c_s2) * cpc_pkg::PROD_W'(up_s2);
			p2_s3 <= cpc_pkg::PROD_W'(crs_s2) * cpc_pkg::PROD_W'(c_s2);
			p3_s3 <= cpc_pkg::PROD_W'(old_s2) * cpc_pkg::PROD_W'(c_s2);
			half_s3 <= hprod[2*cpc_pkg::CNT_W-1:1];
		end
	end

	cpc_pkg::result_t acc_q;
	cpc_pkg::result_t acc_new;
	logic [cpc_pkg::ACC_W+1:0] half_ext;

	always_comb begin
		half_ext = (cpc_pkg::ACC_W+2)'(half_s3);
		acc_new.concordant = sat63({2'b00, acc_q.concordant} + {1'b0, p0_s3});
		acc_new.discordant = sat63({2'b00, acc_q.discordant} + {1'b0, p1_s3});
		acc_new.ties_rows = sat63({2'b00, acc_q.ties_rows} + {1'b0, p2_s3} + half_ext);
		acc_new.ties_columns = sat63({2'b00, acc_q.ties_columns} + {1'b0, p3_s3} + half_ext);
		acc_new.ties_joint = sat63({2'b00, acc_q.ties_joint} + half_ext);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
		end else if (v_s3) begin
			if (last_s3) begin
				acc_q <= '0;
			end else begin
				acc_q <= acc_new;
			end
		end
	end

	// Result queue. The pending count covers results in flight and queued, so a
	// finished table always finds room.
	cpc_pkg::result_t res_mem [cpc_pkg::OUT_DEPTH];
	logic [cpc_pkg::OUT_AW-1:0] wp_q;
	logic [cpc_pkg::OUT_AW-1:0] rp_q;
	logic [cpc_pkg::OUT_AW:0] cnt_q;
	logic push;
	logic pop;
	cpc_pkg::result_t res_out;

	assign push = v_s3 && last_s3;
	assign result_valid = (cnt_q != '0);
	assign pop = result_valid && !result_stall;

	always_ff @(posedge clk) begin
		if (push) begin
			res_mem[wp_q] <= acc_new;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
			cnt_q <= '0;
			pend_q <= '0;
		end else begin
			if (push) begin
				wp_q <= wp_q + 1'b1;
			end
			if (pop) begin
				rp_q <= rp_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
			if ((cell_acc && last_cell) && !pop) begin
				pend_q <= pend_q + 1'b1;
			end else if (pop && !(cell_acc && last_cell)) begin
				pend_q <= pend_q - 1'b1;
			end
		end
	end

	assign res_out = res_mem[rp_q];
	assign concordant = res_out.concordant;
	assign discordant = res_out.discordant;
	assign ties_rows = res_out.ties_rows;
	assign ties_columns = res_out.ties_columns;
	assign ties_joint = res_out.ties_joint;

	// Checks on the internal bookkeeping.
	`CPC_NEVER(a_pend_bound, pend_q > cpc_pkg::PEND_W'(cpc_pkg::OUT_DEPTH))
	`CPC_NEVER(a_queue_within_pend, (cpc_pkg::PEND_W)'(cnt_q) > pend_q)
	`CPC_NEVER(a_no_push_when_full, push && (cnt_q == (cpc_pkg::OUT_AW+1)'(cpc_pkg::OUT_DEPTH)))
	`CPC_ASSERT(a_last_restarts_row, (cell_acc && last_cell) |=> (ci_q == '0))

endmodule

### sim/contingency_pair_counter_core_test.sv
`timescale 1ns / 100ps

// Self-checking bench for the contingency pair counter core.
//
// An initial block builds the whole run up front as a queue of pending steps: cell
// transactions, writes of the column count, and pauses that hold the sender until every
// table result has been taken. A clocked driver feeds the cell channel in bursts with
// random gaps, and the result side stalls on a pattern of its own. A clocked monitor
// watches every accepted transaction, runs its own model of the pair arithmetic on
// each accepted cell, and checks every result transaction against the oldest table
// total still waiting.
module contingency_pair_counter_core_test;

	localparam int CLK_HALF = 5;
	localparam int RESET_CYCLES = 6;
	localparam int RANDOM_CELLS = 2000;
	// Quiet cycles required before a register write or the end of a pause.
	localparam int SETTLE_CYCLES = 8;
	localparam int DRAIN_CYCLES = 16;
	localparam int WATCHDOG_LIMIT = 2000;

	localparam bit [63:0] CAP40 = 64'(cpc_pkg::LIM40);
	localparam bit [63:0] CAP48 = 64'(cpc_pkg::LIM48);
	localparam bit [63:0] CAP63 = 64'(cpc_pkg::LIM63);

	typedef enum logic [1:0] {KIND_CELL, KIND_WIDTH, KIND_DRAIN} step_kind_t;

	typedef struct {
		step_kind_t kind;
		logic [cpc_pkg::CNT_W-1:0] count;
		logic last;
		logic [cpc_pkg::CFG_W-1:0] width;
	} step_t;

	typedef enum logic [1:0] {FLOW_OPEN, FLOW_HELD, FLOW_CHOPPY} flow_mode_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [cpc_pkg::CFG_W-1:0] columns_in_use = '0;
	logic cell_valid = 1'b0;
	logic cell_stall;
	logic [cpc_pkg::CNT_W-1:0] cell_count = '0;
	logic last_cell = 1'b0;
	logic result_valid;
	logic result_stall = 1'b0;
	logic [cpc_pkg::ACC_W-1:0] concordant;
	logic [cpc_pkg::ACC_W-1:0] discordant;
	logic [cpc_pkg::ACC_W-1:0] ties_rows;
	logic [cpc_pkg::ACC_W-1:0] ties_columns;
	logic [cpc_pkg::ACC_W-1:0] ties_joint;

	contingency_pair_counter_core dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.columns_in_use(columns_in_use),
		.cell_valid(cell_valid),
		.cell_stall(cell_stall),
		.cell_count(cell_count),
		.last_cell(last_cell),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.concordant(concordant),
		.discordant(discordant),
		.ties_rows(ties_rows),
		.ties_columns(ties_columns),
		.ties_joint(ties_joint)
	);

	initial begin
		forever #CLK_HALF clk = ~clk;
	end

	// Steps not yet handed to the core, and table totals not yet seen at the output.
	step_t pending_steps[$];
	cpc_pkg::result_t expected_totals[$];
	int cells_queued = 0;
	int mismatches = 0;
	// Registered copy of the number of outstanding tables, so the driver never reads
	// the monitor's queue in the same time step that the monitor changes it.
	int results_owed = 0;

	// Model state: the column setting as last written and the running sums of the
	// table in progress. Every sum is kept in 64 bits and clamped at the width that
	// the core gives it.
	logic [cpc_pkg::CFG_W-1:0] width_setting = cpc_pkg::COLS_RESET;
	bit [63:0] col_sum [cpc_pkg::MAX_COLUMNS];
	bit [63:0] left_run = '0;
	bit [63:0] rows_above = '0;
	bit [63:0] row_run = '0;
	int next_col = 0;
	bit [63:0] conc_sum = '0;
	bit [63:0] disc_sum = '0;
	bit [63:0] row_ties = '0;
	bit [63:0] col_ties = '0;
	bit [63:0] cell_ties = '0;

	function automatic bit [63:0] sat_sum(input bit [63:0] a, input bit [63:0] b,
			input bit [63:0] cap);
		if (a >= cap || b > cap - a)
			return cap;
		return a + b;
	endfunction

	// Folds one accepted cell into the table and, on the last cell, queues the five
	// totals that the core must report and starts a fresh table.
	task automatic tally_cell(input logic [cpc_pkg::CNT_W-1:0] count, input logic is_last);
		bit [63:0] c;
		bit [63:0] old;
		bit [63:0] upright;
		bit [63:0] half;
		int cols;
		int j;
		cpc_pkg::result_t totals;

		// A zero setting means one column; anything above the memory depth is clamped.
		cols = int'(width_setting);
		if (cols == 0)
			cols = 1;
		if (cols > cpc_pkg::MAX_COLUMNS)
			cols = cpc_pkg::MAX_COLUMNS;
		j = next_col;
		c = 64'(count);
		old = col_sum[j];

		// Cells above and to the right: everything in earlier rows minus the columns up
		// to and including this one. Saturated sums can make that negative; use zero.
		if (left_run > rows_above || old > rows_above - left_run)
			upright = '0;
		else
			upright = rows_above - left_run - old;
		half = (c == 0) ? 64'd0 : (c * (c - 64'd1)) >> 1;

		conc_sum = sat_sum(conc_sum, c * left_run, CAP63);
		disc_sum = sat_sum(disc_sum, c * upright, CAP63);
		row_ties = sat_sum(row_ties, row_run * c, CAP63);
		row_ties = sat_sum(row_ties, half, CAP63);
		col_ties = sat_sum(col_ties, old * c, CAP63);
		col_ties = sat_sum(col_ties, half, CAP63);
		cell_ties = sat_sum(cell_ties, half, CAP63);

		left_run = sat_sum(left_run, old, CAP48);
		col_sum[j] = sat_sum(old, c, CAP40);
		row_run = sat_sum(row_run, c, CAP40);

		// The row also ends here when the setting was lowered below the current column.
		if (j + 1 >= cols) begin
			rows_above = sat_sum(rows_above, row_run, CAP48);
			row_run = '0;
			left_run = '0;
			next_col = 0;
		end else begin
			next_col = j + 1;
		end

		if (is_last) begin
			totals.concordant = conc_sum[cpc_pkg::ACC_W-1:0];
			totals.discordant = disc_sum[cpc_pkg::ACC_W-1:0];
			totals.ties_rows = row_ties[cpc_pkg::ACC_W-1:0];
			totals.ties_columns = col_ties[cpc_pkg::ACC_W-1:0];
			totals.ties_joint = cell_ties[cpc_pkg::ACC_W-1:0];
			expected_totals.push_back(totals);
			foreach (col_sum[k])
				col_sum[k] = '0;
			left_run = '0;
			rows_above = '0;
			row_run = '0;
			next_col = 0;
			conc_sum = '0;
			disc_sum = '0;
			row_ties = '0;
			col_ties = '0;
			cell_ties = '0;
		end
	endtask

	task automatic check_field(input string name, input logic [cpc_pkg::ACC_W-1:0] want,
			input logic [cpc_pkg::ACC_W-1:0] got);
		if (got !== want) begin
			$error("%s: expected %0d, actual %0d", name, want, got);
			mismatches++;
		end
	endtask

	// Stimulus helpers used by the initial block.
	task automatic add_cell(input logic [cpc_pkg::CNT_W-1:0] count, input logic is_last);
		step_t s;
		s.kind = KIND_CELL;
		s.count = count;
		s.last = is_last;
		s.width = '0;
		pending_steps.push_back(s);
		cells_queued++;
	endtask

	task automatic add_step(input step_kind_t kind, input logic [cpc_pkg::CFG_W-1:0] width);
		step_t s;
		s.kind = kind;
		s.count = '0;
		s.last = 1'b0;
		s.width = width;
		pending_steps.push_back(s);
	endtask

	// Counts lean toward small values so ties and products stay readable, with the
	// extremes and full-range values mixed in.
	function automatic logic [cpc_pkg::CNT_W-1:0] random_count();
		int pick;
		pick = $urandom_range(0, 9);
		if (pick == 0)
			return '0;
		if (pick == 1)
			return '1;
		if (pick < 6)
			return cpc_pkg::CNT_W'($urandom_range(0, 15));
		return cpc_pkg::CNT_W'($urandom);
	endfunction

	function automatic logic [cpc_pkg::CFG_W-1:0] random_width();
		int pick;
		pick = $urandom_range(0, 9);
		if (pick == 0)
			return '0;
		if (pick == 1)
			return cpc_pkg::CFG_W'(cpc_pkg::MAX_COLUMNS);
		if (pick == 2)
			return cpc_pkg::CFG_W'($urandom_range(cpc_pkg::MAX_COLUMNS + 1, 127));
		if (pick == 3)
			return cpc_pkg::CFG_W'($urandom_range(9, cpc_pkg::MAX_COLUMNS));
		return cpc_pkg::CFG_W'($urandom_range(1, 8));
	endfunction

	function automatic int effective_columns(input logic [cpc_pkg::CFG_W-1:0] width);
		if (width == 0)
			return 1;
		if (width > cpc_pkg::MAX_COLUMNS)
			return cpc_pkg::MAX_COLUMNS;
		return int'(width);
	endfunction

	// Sender. A step is taken from the queue only when nothing is on the channels or the
	// transaction on them has just been accepted. Register writes and pauses wait until
	// no table is outstanding and the core has had a few quiet cycles.
	int gap_left = 0;
	int burst_left = 0;
	int settled_cycles = 0;

	always @(posedge clk) begin : drive_cells
		step_t head;
		logic drive_cell;
		logic drive_cfg;
		logic busy;

		if (arst_n) begin
			if (results_owed == 0 && !cell_valid && !cfg_valid)
				settled_cycles++;
			else
				settled_cycles = 0;

			busy = (cell_valid && cell_stall) || (cfg_valid && !cfg_ready);
			if (!busy) begin
				drive_cell = 1'b0;
				drive_cfg = 1'b0;
				head = '{KIND_CELL, '0, 1'b0, '0};
				if (pending_steps.size() != 0) begin
					head = pending_steps[0];
					if (head.kind == KIND_CELL) begin
						if (gap_left > 0) begin
							gap_left--;
						end else begin
							drive_cell = 1'b1;
							void'(pending_steps.pop_front());
							if (burst_left > 0) begin
								burst_left--;
							end else begin
								// New burst; about one in four follows with no gap at all.
								burst_left = $urandom_range(0, 24);
								gap_left = ($urandom_range(0, 3) == 0) ? 0 :
									$urandom_range(1, 10);
							end
						end
					end else if (settled_cycles >= SETTLE_CYCLES) begin
						drive_cfg = (head.kind == KIND_WIDTH);
						void'(pending_steps.pop_front());
						settled_cycles = 0;
					end
				end
				cell_valid <= drive_cell;
				if (drive_cell) begin
					cell_count <= head.count;
					last_cell <= head.last;
				end
				cfg_valid <= drive_cfg;
				if (drive_cfg)
					columns_in_use <= head.width;
			end
		end
	end

	// Result side back-pressure: stretches that never stall, solid stalls, and stretches
	// that stall on a coin toss each cycle.
	flow_mode_t flow_mode = FLOW_OPEN;
	int flow_left = 0;

	always @(posedge clk) begin : stall_results
		if (flow_left > 0) begin
			flow_left--;
		end else begin
			flow_mode = flow_mode_t'($urandom_range(0, 2));
			flow_left = (flow_mode == FLOW_HELD) ? $urandom_range(1, 12) :
				$urandom_range(0, 40);
		end
		case (flow_mode)
			FLOW_OPEN: result_stall <= 1'b0;
			FLOW_HELD: result_stall <= 1'b1;
			default: result_stall <= 1'($urandom_range(0, 1));
		endcase
	end

	// Monitor. Results are checked before the cells of this edge are modeled: a table
	// cannot be reported in the same cycle that its last cell goes in.
	always @(posedge clk) begin : watch_channels
		cpc_pkg::result_t want;

		if (arst_n) begin
			if (result_valid && !result_stall) begin
				if (expected_totals.size() == 0) begin
					$error("result transaction with no table outstanding");
					mismatches++;
				end else begin
					want = expected_totals.pop_front();
					check_field("concordant", want.concordant, concordant);
					check_field("discordant", want.discordant, discordant);
					check_field("ties_rows", want.ties_rows, ties_rows);
					check_field("ties_columns", want.ties_columns, ties_columns);
					check_field("ties_joint", want.ties_joint, ties_joint);
				end
			end
			if (cfg_valid && cfg_ready)
				width_setting = columns_in_use;
			if (cell_valid && !cell_stall)
				tally_cell(cell_count, last_cell);
			results_owed <= expected_totals.size();
		end
	end

	// Watchdog: a long run of cycles with no transaction on any channel means the core
	// has hung or dropped a result.
	int stuck_cycles = 0;

	always @(posedge clk) begin : watchdog
		if (!arst_n || (cell_valid && !cell_stall) || (result_valid && !result_stall) ||
				(cfg_valid && cfg_ready)) begin
			stuck_cycles <= 0;
		end else if (stuck_cycles >= WATCHDOG_LIMIT) begin
			$display("contingency_pair_counter_core: mismatch");
			$finish;
		end else begin
			stuck_cycles <= stuck_cycles + 1;
		end
	end

	initial begin : run_tables
		logic [cpc_pkg::CFG_W-1:0] width;
		int cols;
		int rows;
		int span;
		int tables;

		// Reset width of 64 columns: a table of extreme counts that ends mid-row.
		add_cell('1, 1'b0);
		add_cell('0, 1'b0);
		add_cell(16'd1, 1'b0);
		add_cell('1, 1'b0);
		add_cell(16'd2, 1'b1);
		// A zero setting acts as one column, so every cell is a row of its own.
		add_step(KIND_WIDTH, '0);
		add_cell(16'd3, 1'b0);
		add_cell('1, 1'b0);
		add_cell(16'd7, 1'b0);
		add_cell(16'd1, 1'b1);
		// The widest setting acts as 64; first a table of a single cell.
		add_step(KIND_WIDTH, '1);
		add_cell(16'd40000, 1'b1);
		add_cell(16'd2, 1'b0);
		add_cell(16'd5, 1'b1);
		// A full two-by-three table.
		add_step(KIND_WIDTH, 7'd3);
		add_cell(16'd1, 1'b0);
		add_cell(16'd2, 1'b0);
		add_cell(16'd3, 1'b0);
		add_cell(16'd4, 1'b0);
		add_cell(16'd5, 1'b0);
		add_cell(16'd6, 1'b1);
		// Setting lowered under the current column in the middle of a row: the next
		// cell still lands in column four and closes the row.
		add_step(KIND_WIDTH, 7'd5);
		add_cell(16'd1, 1'b0);
		add_cell(16'd2, 1'b0);
		add_cell(16'd3, 1'b0);
		add_cell(16'd4, 1'b0);
		add_step(KIND_WIDTH, 7'd2);
		add_cell(16'd9, 1'b0);
		add_cell(16'd1, 1'b0);
		add_cell(16'd2, 1'b1);
		add_step(KIND_DRAIN, '0);

		// Random phases of whole tables with random counts. Some tables end mid-row,
		// and some phases leave a partial table open across the next register write.
		cols = 2;
		while (cells_queued < RANDOM_CELLS + 25) begin
			if ($urandom_range(0, 3) == 0) begin
				width = random_width();
				add_step(KIND_WIDTH, width);
				cols = effective_columns(width);
			end
			tables = $urandom_range(1, 4);
			repeat (tables) begin
				rows = (cols > 16) ? $urandom_range(1, 2) : $urandom_range(1, 6);
				span = rows * cols;
				if ($urandom_range(0, 4) == 0)
					span = span - $urandom_range(0, cols - 1);
				for (int k = 0; k < span; k++)
					add_cell(random_count(), k == span - 1);
				if ($urandom_range(0, 9) == 0)
					add_step(KIND_DRAIN, '0);
			end
			if ($urandom_range(0, 5) == 0) begin
				span = $urandom_range(1, cols);
				repeat (span)
					add_cell(random_count(), 1'b0);
			end
		end
		// Close whatever table is still open so that its result is checked as well.
		add_cell(random_count(), 1'b1);

		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Settled values are read at the falling edge, away from the driver's updates.
		while (pending_steps.size() != 0 || cell_valid || cfg_valid || results_owed != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);

		if (expected_totals.size() != 0)
			$error("%0d table results never arrived", expected_totals.size());
		if (mismatches == 0 && expected_totals.size() == 0) begin
			$display("contingency_pair_counter_core: match");
		end else begin
			$display("contingency_pair_counter_core: mismatch");
		end
		$finish;
	end

endmodule

### filelist.f
+incdir+rtl/core
rtl/core/cpc_pkg.sv
rtl/core/contingency_pair_counter_core.sv
sim/contingency_pair_counter_core_test.sv
